/* rtl/tts_pkg.sv */
// ----------------------------------------------------------------------------
// Text token signature package
// Payload types, limits and byte classification helpers for the signature block.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Only the first tokens of the joined text are hashed.
  localparam logic [15:0] TOKEN_LIMIT = 16'd12;
  // Length of the raw fallback prefix.
  localparam logic [6:0]  RAW_LIMIT   = 7'd64;
  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [7:0]  SPACE_CHAR  = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [15:0] signature;
    logic [15:0] token_total;
    logic        raw_prefix_used;
    logic [3:0]  rhythm_minutes;
  } out_t;

  function automatic logic is_space(input logic [7:0] b);
    is_space = (b inside {[8'h09:8'h0D], 8'h20});
  endfunction

  // ASCII punctuation plus the bytes of the UTF-8 curly quotes.
  function automatic logic is_punct(input logic [7:0] b);
    is_punct = (b inside {8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h21, 8'h3F, 8'h28, 8'h29,
                          8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h22, 8'h27,
                          8'hE2, 8'h80, 8'h9C, 8'h9D, 8'h98, 8'h99});
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b inside {[8'h41:8'h5A]}) ? (b + 8'h20) : b;
  endfunction

  // Thresholds standing in for 12 - floor(log1.6(count + 1)), clamped to 3..10.
  function automatic logic [3:0] minutes_for(input logic [15:0] cnt);
    if (cnt < 16'd4)       minutes_for = 4'd10;
    else if (cnt < 16'd6)  minutes_for = 4'd9;
    else if (cnt < 16'd10) minutes_for = 4'd8;
    else if (cnt < 16'd16) minutes_for = 4'd7;
    else if (cnt < 16'd26) minutes_for = 4'd6;
    else if (cnt < 16'd42) minutes_for = 4'd5;
    else if (cnt < 16'd68) minutes_for = 4'd4;
    else                   minutes_for = 4'd3;
  endfunction

endpackage

/* rtl/text_token_signature.sv */
// ----------------------------------------------------------------------------
// Text token signature
// Streams text bytes, tokenizes and trims them, and reports a weighted hash.
// ----------------------------------------------------------------------------
// Usage: text enters one word per cycle while in_stall is low, on the in_
// channel (in_valid, in_stall, in_data); the word carrying end_of_text
// closes the text and produces one result word on the out_ channel
// (out_valid, out_stall, out_data). Other words produce no result.
// Throughput is one input word per clock while in_stall stays low. A word
// is held in the input register and updates the token state as it leaves
// it; the final word's result is loaded into the output register at the
// same clock, which raises out_valid.
// The per-word update is up to two 16 x 8 multiply-adds on the joined-text hash
// and one on the raw-prefix hash, all done in the same cycle.
// Reset clears all token state and the valid bits of both registers; after
// each result the state returns to its reset values, so the next word starts
// a new text. While a result waits under out_stall, words that end no text
// keep flowing; a second final word waits in the input register, and
// in_stall rises only then.
// ----------------------------------------------------------------------------
module text_token_signature
  import tts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic        in_valid_r;
  in_t         in_data_r;
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        out_data_nxt;
  logic        advance;

  logic        has_letter_r, has_letter_nxt;
  logic [15:0] token_cnt_r, token_cnt_nxt;
  logic [15:0] joined_pos_r, joined_pos_nxt;
  logic [15:0] commit_sum_r, commit_sum_nxt;
  logic [15:0] pend_sum_r, pend_sum_nxt;
  logic [15:0] pend_len_r, pend_len_nxt;
  logic [15:0] raw_sum_r, raw_sum_nxt;
  logic [6:0]  raw_idx_r, raw_idx_nxt;

  logic [7:0]  b;
  logic [7:0]  lc;
  logic [15:0] raw_pos;
  logic [15:0] punct_pos;
  logic [15:0] pend_len_eff;
  logic [15:0] pend_sum_eff;
  logic [15:0] sep_pos;
  logic [15:0] letter_pos;
  logic        add_sep;
  logic [15:0] cnt_new;

  // A final word may only leave the input register when the output slot is free.
  assign advance  = in_valid_r && !(in_data_r.end_of_text && out_valid_r && out_stall);
  assign in_stall = in_valid_r && !advance;

  assign b  = in_data_r.text_byte;
  assign lc = to_lower(b);

  assign raw_pos   = {9'd0, raw_idx_r} + 16'd1;
  assign punct_pos = joined_pos_r + pend_len_r + 16'd1;

  // Pending punctuation only exists inside a token that already has a letter.
  assign pend_len_eff = has_letter_r ? pend_len_r : 16'd0;
  assign pend_sum_eff = has_letter_r ? pend_sum_r : 16'd0;

  assign cnt_new = (!has_letter_r && token_cnt_r != COUNT_MAX) ? token_cnt_r + 16'd1
                                                               : token_cnt_r;
  assign add_sep = !has_letter_r && (cnt_new > 16'd1) && (cnt_new <= TOKEN_LIMIT);
  assign sep_pos = joined_pos_r + 16'd1;
  assign letter_pos = joined_pos_r + {15'd0, add_sep} + pend_len_eff + 16'd1;

  always_comb begin
    has_letter_nxt = has_letter_r;
    token_cnt_nxt  = token_cnt_r;
    joined_pos_nxt = joined_pos_r;
    commit_sum_nxt = commit_sum_r;
    pend_sum_nxt   = pend_sum_r;
    pend_len_nxt   = pend_len_r;
    raw_sum_nxt    = raw_sum_r;
    raw_idx_nxt    = raw_idx_r;

    if (raw_idx_r < RAW_LIMIT) begin
      raw_sum_nxt = raw_sum_r + raw_pos * {8'd0, b};
      raw_idx_nxt = raw_idx_r + 7'd1;
    end

    if (is_space(b)) begin
      has_letter_nxt = 1'b0;
      pend_sum_nxt   = 16'd0;
      pend_len_nxt   = 16'd0;
    end else if (is_punct(b)) begin
      if (has_letter_r && token_cnt_r <= TOKEN_LIMIT) begin
        pend_sum_nxt = pend_sum_r + punct_pos * {8'd0, b};
        pend_len_nxt = pend_len_r + 16'd1;
      end
    end else begin
      has_letter_nxt = 1'b1;
      token_cnt_nxt  = cnt_new;
      if (!has_letter_r) begin
        pend_sum_nxt = 16'd0;
        pend_len_nxt = 16'd0;
      end
      if (cnt_new <= TOKEN_LIMIT) begin
        // Separator, then pending punctuation, then the letter itself.
        commit_sum_nxt = commit_sum_r + pend_sum_eff + letter_pos * {8'd0, lc}
                       + (add_sep ? sep_pos * {8'd0, SPACE_CHAR} : 16'd0);
        joined_pos_nxt = letter_pos;
        pend_sum_nxt   = 16'd0;
        pend_len_nxt   = 16'd0;
      end
    end

    out_data_nxt.token_total     = token_cnt_nxt;
    out_data_nxt.raw_prefix_used = (token_cnt_nxt == 16'd0);
    out_data_nxt.signature       = (token_cnt_nxt == 16'd0) ? raw_sum_nxt : commit_sum_nxt;
    out_data_nxt.rhythm_minutes  = minutes_for(token_cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_letter_r <= 1'b0;
      token_cnt_r  <= 16'd0;
      joined_pos_r <= 16'd0;
      commit_sum_r <= 16'd0;
      pend_sum_r   <= 16'd0;
      pend_len_r   <= 16'd0;
      raw_sum_r    <= 16'd0;
      raw_idx_r    <= 7'd0;
    end else if (advance) begin
      if (in_data_r.end_of_text) begin
        has_letter_r <= 1'b0;
        token_cnt_r  <= 16'd0;
        joined_pos_r <= 16'd0;
        commit_sum_r <= 16'd0;
        pend_sum_r   <= 16'd0;
        pend_len_r   <= 16'd0;
        raw_sum_r    <= 16'd0;
        raw_idx_r    <= 7'd0;
      end else begin
        has_letter_r <= has_letter_nxt;
        token_cnt_r  <= token_cnt_nxt;
        joined_pos_r <= joined_pos_nxt;
        commit_sum_r <= commit_sum_nxt;
        pend_sum_r   <= pend_sum_nxt;
        pend_len_r   <= pend_len_nxt;
        raw_sum_r    <= raw_sum_nxt;
        raw_idx_r    <= raw_idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_data_r.end_of_text) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_data_r.end_of_text) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
